// ----- rtl/core/tgf_pkg.sv -----
// ----------------------------------------------------------------------------
// tgf_pkg
// shared types, constants and the quarter-wave cosine table of the gait unit
// ----------------------------------------------------------------------------
package tgf_pkg;

    localparam int LEG_COUNT        = 6;
    localparam int LEG_W            = 3;
    localparam int TRIG_TABLE_DEPTH = 256;
    localparam int TRIG_LOG2        = $clog2(TRIG_TABLE_DEPTH);
    localparam int TAB_IDX_W        = TRIG_LOG2 + 1;
    localparam int QUEUE_DEPTH_DEF  = 4;
    localparam int DIV_STEPS        = 48;
    localparam int DIV_CNT_W        = $clog2(DIV_STEPS);

    localparam logic [15:0]          MIN_PERIOD  = 16'd200;
    localparam logic [63:0]          PI_HALF_Q30 = 64'd1686629713;
    localparam logic [LEG_COUNT-1:0] LEG_GROUP   = 6'b100110;

    localparam logic [2:0] CFG_STRIDE_LENGTH  = 3'd0;
    localparam logic [2:0] CFG_STEP_HEIGHT    = 3'd1;
    localparam logic [2:0] CFG_CYCLE_PERIOD   = 3'd2;
    localparam logic [2:0] CFG_STRIDE_WIDTH   = 3'd3;
    localparam logic [2:0] CFG_NEUTRAL_REACH  = 3'd4;
    localparam logic [2:0] CFG_NEUTRAL_HEIGHT = 3'd5;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_START  = 2'd1,
        CMD_STOP   = 2'd2,
        CMD_FREEZE = 2'd3
    } t_in_mode;

    typedef enum logic [1:0] {
        GAIT_IDLE = 2'd0,
        GAIT_WALK = 2'd1,
        GAIT_STOP = 2'd2
    } t_gait;

    typedef enum logic [3:0] {
        B_IDLE, B_LOAD, B_DIV, B_STRIDE, B_LEG, B_TA, B_TB, B_MX, B_MY, B_MZ, B_OUT
    } t_bstate;

    typedef struct packed {
        logic               neutral;
        logic [31:0]        elapsed;
        logic signed [15:0] fwd;
        logic signed [15:0] side;
    } t_cmd;

    typedef struct packed {
        logic [14:0]        stride_len;
        logic [14:0]        lift_height;
        logic [15:0]        cycle_period;
        logic signed [15:0] side_stride;
        logic signed [15:0] neutral_reach;
        logic signed [15:0] neutral_height;
    } t_cfg;

    typedef logic [15:0] t_tab [0:TRIG_TABLE_DEPTH];

    function automatic logic [63:0] taylor_div(int k);
        case (k)
            1:       taylor_div = 64'd2;
            2:       taylor_div = 64'd12;
            3:       taylor_div = 64'd30;
            4:       taylor_div = 64'd56;
            5:       taylor_div = 64'd90;
            default: taylor_div = 64'd132;
        endcase
    endfunction

    function automatic logic [63:0] cdiv(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, b}) begin
                r    = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_tab build_tab();
        t_tab               tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        for (int i = 0; i <= TRIG_TABLE_DEPTH; i++) begin
            x    = (PI_HALF_Q30 * 64'(i)) >> TRIG_LOG2;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = signed'(term);
            for (int k = 1; k <= 6; k++) begin
                term = (term * x2) >> 30;
                term = cdiv(term, taylor_div(k));
                if (k % 2 == 1) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (unsigned'(sum) + 64'd16384) >> 15;
            if (v > 64'd32768) begin
                v = 64'd32768;
            end
            tab[i] = v[15:0];
        end
        return tab;
    endfunction

    localparam t_tab QTAB = build_tab();

    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        if (v > 19'sd32767) begin
            sat16 = 16'sh7fff;
        end else if (v < -19'sd32768) begin
            sat16 = -16'sh8000;
        end else begin
            sat16 = v[15:0];
        end
    endfunction

endpackage

// ----- rtl/core/tgf_queue.sv -----
// ----------------------------------------------------------------------------
// tgf_queue
// small command fifo between the front and the back, registered read
// ----------------------------------------------------------------------------
module tgf_queue #(
    parameter int DEPTH = tgf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  tgf_pkg::t_cmd i_data,
    output logic         o_full,
    input  logic         i_pop,
    output tgf_pkg::t_cmd o_data,
    output logic         o_empty
);
    import tgf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    t_cmd             r_rd_data;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_rd_data;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            ptr_inc = '0;
        end else begin
            ptr_inc = p + 1'b1;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wr_ptr] <= i_data;
        end
        if (i_pop) begin
            r_rd_data <= mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue underflow");
`endif

endmodule

// ----- rtl/core/tgf_front.sv -----
// ----------------------------------------------------------------------------
// tgf_front
// accepts commands, keeps gait mode, cycle origin and config registers
// ----------------------------------------------------------------------------
module tgf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [63:0]   i_s_tdata,
    input  logic [1:0]    i_s_tuser,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    output tgf_pkg::t_cfg o_cfg,
    output logic          o_push,
    output tgf_pkg::t_cmd o_cmd,
    input  logic          i_full
);
    import tgf_pkg::*;

    t_cfg  r_cfg;
    t_gait r_mode;
    t_gait n_mode;
    logic [31:0] r_origin;
    logic [31:0] n_origin;

    logic               accept;
    logic [31:0]        tick;
    logic [31:0]        origin_eff;
    logic [31:0]        elapsed;
    logic signed [15:0] fwd_raw;
    logic signed [15:0] side_raw;
    logic signed [15:0] fwd_c;
    logic signed [15:0] side_c;
    logic               neutral;

    assign o_s_tready  = !i_full;
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;
    assign accept      = i_s_tvalid && o_s_tready;
    assign tick        = i_s_tdata[31:0];
    assign fwd_raw     = i_s_tdata[47:32];
    assign side_raw    = i_s_tdata[63:48];

    function automatic logic signed [15:0] clamp_ratio(input logic signed [15:0] r);
        if (r > 16'sd16384) begin
            clamp_ratio = 16'sd16384;
        end else if (r < -16'sd16384) begin
            clamp_ratio = -16'sd16384;
        end else begin
            clamp_ratio = r;
        end
    endfunction

    always_comb begin
        fwd_c      = clamp_ratio(fwd_raw);
        side_c     = clamp_ratio(side_raw);
        origin_eff = (r_origin == '0) ? tick : r_origin;
        elapsed    = tick - origin_eff;
        n_mode     = r_mode;
        n_origin   = r_origin;
        neutral    = 1'b1;
        o_push     = 1'b0;
        if (accept) begin
            case (t_in_mode'(i_s_tuser))
                CMD_START: begin
                    if (r_mode == GAIT_IDLE || r_mode == GAIT_STOP) begin
                        n_mode = GAIT_WALK;
                    end
                end
                CMD_STOP: begin
                    if (r_mode == GAIT_WALK) begin
                        n_mode = GAIT_STOP;
                    end
                end
                CMD_FREEZE: begin
                    n_mode = GAIT_IDLE;
                end
                default: begin
                    o_push   = 1'b1;
                    n_origin = origin_eff;
                    if (r_mode == GAIT_WALK || r_mode == GAIT_STOP) begin
                        neutral = (r_mode == GAIT_STOP) &&
                                  (elapsed >= {16'h0, r_cfg.cycle_period});
                        if (neutral) begin
                            n_mode = GAIT_IDLE;
                        end
                    end else begin
                        n_mode = GAIT_IDLE;
                    end
                end
            endcase
        end
        o_cmd.neutral = neutral;
        o_cmd.elapsed = elapsed;
        o_cmd.fwd     = fwd_c;
        o_cmd.side    = side_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= GAIT_IDLE;
            r_origin <= '0;
        end else begin
            r_mode   <= n_mode;
            r_origin <= n_origin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stride_len     <= 15'd960;
            r_cfg.lift_height    <= 15'd480;
            r_cfg.cycle_period   <= 16'd1000;
            r_cfg.side_stride    <= 16'sd0;
            r_cfg.neutral_reach  <= 16'sd1600;
            r_cfg.neutral_height <= -16'sd1280;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_STRIDE_LENGTH:  r_cfg.stride_len  <= i_cfg_data[14:0];
                CFG_STEP_HEIGHT:    r_cfg.lift_height <= i_cfg_data[14:0];
                CFG_CYCLE_PERIOD: begin
                    if (i_cfg_data >= MIN_PERIOD) begin
                        r_cfg.cycle_period <= i_cfg_data;
                    end
                end
                CFG_STRIDE_WIDTH:   r_cfg.side_stride    <= i_cfg_data;
                CFG_NEUTRAL_REACH:  r_cfg.neutral_reach  <= i_cfg_data;
                CFG_NEUTRAL_HEIGHT: r_cfg.neutral_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/core/tgf_back.sv -----
// ----------------------------------------------------------------------------
// tgf_back
// phase divider and per-leg trajectory sequencer with output register
// ----------------------------------------------------------------------------
module tgf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tgf_pkg::t_cfg i_cfg,
    input  logic          i_empty,
    output logic          o_pop,
    input  tgf_pkg::t_cmd i_cmd,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [55:0]   o_m_tdata,
    output logic          o_m_tuser,
    output logic          o_m_tlast
);
    import tgf_pkg::*;

    t_bstate r_state;
    t_bstate n_state;

    t_cmd               r_cmd;
    logic [47:0]        r_div_sh;
    logic [15:0]        r_rem;
    logic [15:0]        r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic signed [31:0] r_ex;
    logic signed [31:0] r_ey;
    logic [LEG_W-1:0]   r_leg;
    logic               r_swing;
    logic [16:0]        r_ucos;
    logic [16:0]        r_usin;
    logic               r_neg;
    logic signed [16:0] r_w;
    logic               r_tsel;
    logic [33:0]        r_prod;
    logic [15:0]        r_cos;
    logic [15:0]        r_sin;
    logic signed [17:0] r_dx;
    logic signed [17:0] r_dy;
    logic signed [17:0] r_dz;

    logic               r_out_valid;
    logic [LEG_W-1:0]   r_out_leg;
    logic signed [15:0] r_out_x;
    logic signed [15:0] r_out_y;
    logic signed [15:0] r_out_z;
    logic               r_out_swing;
    logic               r_out_last;

    logic               ld;
    logic [16:0]        trial;
    logic               ge;
    logic [15:0]        lp;
    logic               swing_c;
    logic [15:0]        s;
    logic [16:0]        s2;
    logic [16:0]        u_cos;
    logic [16:0]        u_sin;
    logic signed [16:0] w_c;
    logic [16:0]        u;
    logic [TAB_IDX_W-1:0] idx;
    logic [TAB_IDX_W-1:0] idx1;
    logic [15:0]        frac;
    logic [33:0]        prod_a;
    logic [33:0]        prod_b;
    logic [33:0]        tab_sum;
    logic signed [15:0] len_s;
    logic signed [31:0] ex_c;
    logic signed [31:0] ey_c;
    logic signed [16:0] m;
    logic signed [48:0] pxy;
    logic signed [48:0] pxy_r;
    logic [30:0]        pz;
    logic [30:0]        pz_r;

    always_comb begin
        trial   = {r_rem, r_div_sh[47]};
        ge      = (trial >= {1'b0, i_cfg.cycle_period});
        lp      = r_quo + (LEG_GROUP[r_leg] ? 16'h8000 : 16'h0000);
        swing_c = !lp[15];
        s       = {lp[14:0], 1'b0};
        s2      = {s, 1'b0};
        u_cos   = s[15] ? 17'((17'h10000 - {1'b0, s}) << 1) : s2;
        u_sin   = s[15] ? (s2 - 17'h10000) : (17'h10000 - s2);
        w_c     = signed'(17'h08000 - {1'b0, s});
        u       = r_tsel ? r_usin : r_ucos;
        idx     = TAB_IDX_W'(u >> (16 - TRIG_LOG2));
        frac    = 16'(u << TRIG_LOG2);
        idx1    = (idx == TAB_IDX_W'(TRIG_TABLE_DEPTH)) ? idx : idx + 1'b1;
        prod_a  = QTAB[idx] * (17'h10000 - {1'b0, frac});
        prod_b  = QTAB[idx1] * frac;
        tab_sum = r_prod + prod_b + 34'd32768;
        len_s   = signed'({1'b0, i_cfg.stride_len});
        ex_c    = len_s * r_cmd.fwd;
        ey_c    = signed'({{2{i_cfg.side_stride[15]}}, i_cfg.side_stride, 14'h0})
                  + len_s * r_cmd.side;
        if (r_swing) begin
            m = r_neg ? signed'({1'b0, r_cos}) : -signed'({1'b0, r_cos});
        end else begin
            m = r_w;
        end
        pxy   = ((r_state == B_MX) ? r_ex : r_ey) * m;
        pxy_r = (pxy + (49'sd1 <<< 29)) >>> 30;
        pz    = {1'b0, i_cfg.lift_height} * r_sin;
        pz_r  = (pz + 31'd16384) >> 15;
        ld    = (r_state == B_OUT) && (!r_out_valid || i_m_tready);
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = B_LOAD;
                end
            end
            B_LOAD:   n_state = i_cmd.neutral ? B_STRIDE : B_DIV;
            B_DIV: begin
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = B_STRIDE;
                end
            end
            B_STRIDE: n_state = B_LEG;
            B_LEG: begin
                if (r_cmd.neutral) begin
                    n_state = B_OUT;
                end else begin
                    n_state = swing_c ? B_TA : B_MX;
                end
            end
            B_TA:     n_state = B_TB;
            B_TB:     n_state = r_tsel ? B_MX : B_TA;
            B_MX:     n_state = B_MY;
            B_MY:     n_state = r_swing ? B_MZ : B_OUT;
            B_MZ:     n_state = B_OUT;
            B_OUT: begin
                if (ld) begin
                    n_state = (r_leg == LEG_W'(LEG_COUNT - 1)) ? B_IDLE : B_LEG;
                end
            end
            default:  n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ld) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_LOAD: begin
                r_cmd    <= i_cmd;
                r_div_sh <= {i_cmd.elapsed, 16'h0};
                r_rem    <= '0;
                r_cnt    <= '0;
                r_leg    <= '0;
            end
            B_DIV: begin
                r_rem    <= ge ? 16'(trial - {1'b0, i_cfg.cycle_period}) : trial[15:0];
                r_quo    <= {r_quo[14:0], ge};
                r_div_sh <= {r_div_sh[46:0], 1'b0};
                r_cnt    <= r_cnt + 1'b1;
            end
            B_STRIDE: begin
                r_ex <= ex_c;
                r_ey <= ey_c;
            end
            B_LEG: begin
                r_swing <= swing_c && !r_cmd.neutral;
                r_ucos  <= u_cos;
                r_usin  <= u_sin;
                r_neg   <= s[15];
                r_w     <= w_c;
                r_tsel  <= 1'b0;
                r_dx    <= '0;
                r_dy    <= '0;
                r_dz    <= '0;
            end
            B_TA: begin
                r_prod <= prod_a;
            end
            B_TB: begin
                if (r_tsel) begin
                    r_sin <= tab_sum[31:16];
                end else begin
                    r_cos <= tab_sum[31:16];
                end
                r_tsel <= 1'b1;
            end
            B_MX: r_dx <= pxy_r[17:0];
            B_MY: r_dy <= pxy_r[17:0];
            B_MZ: r_dz <= signed'({2'b00, pz_r[15:0]});
            B_OUT: begin
                if (ld) begin
                    r_out_leg   <= r_leg;
                    r_out_x     <= sat16(19'(i_cfg.neutral_reach) + 19'(r_dx));
                    r_out_y     <= sat16(19'(r_dy));
                    r_out_z     <= sat16(19'(i_cfg.neutral_height) + 19'(r_dz));
                    r_out_swing <= r_swing;
                    r_out_last  <= (r_leg == LEG_W'(LEG_COUNT - 1));
                    r_leg       <= r_leg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'h0, r_out_z, r_out_y, r_out_x, r_out_leg};
    assign o_m_tuser  = r_out_swing;
    assign o_m_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    a_last_on_final_leg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tdata[2:0] == LEG_W'(LEG_COUNT - 1))))
        else $error("tlast not on final leg");
    a_div_only_walking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV) |-> !r_cmd.neutral)
        else $error("divider run for neutral tick");
`endif

endmodule

// ----- rtl/core/tripod_gait_foot_trajectory_unit.sv -----
// ----------------------------------------------------------------------------
// tripod_gait_foot_trajectory_unit
// tripod gait generator: six foot targets for each millisecond tick
// ----------------------------------------------------------------------------
// channel  dir  handshake                  payload
// s        in   i_s_tvalid / o_s_tready    tdata tick,fwd,side  tuser mode
// m        out  o_m_tvalid / i_m_tready    tdata leg,x,y,z  tuser swing  tlast
// cfg      in   i_cfg_valid / o_cfg_ready  index, data
//
// a walking tick pops, loads and runs the 48-step phase divider, then steps
// each of the three swing legs through two table lookups and three multiplies
// and each of the three stance legs through its x and y multiplies
// a neutral tick skips the divider and table steps
// control items are taken by the front and not queued; a command queue parts front
// and back, and a stalled output register holds only the back
// synchronous active-low reset restores register defaults and idle mode
// ----------------------------------------------------------------------------
module tripod_gait_foot_trajectory_unit #(
    parameter int QUEUE_DEPTH = tgf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,    // tick_ms, forward_ratio, sideways_ratio
    input  logic [1:0]  i_s_tuser,    // mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,    // leg, foot_x, foot_y, foot_z
    output logic        o_m_tuser,    // in_swing
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import tgf_pkg::*;

    t_cfg cfg;
    t_cmd push_cmd;
    t_cmd pop_cmd;
    logic push;
    logic full;
    logic pop;
    logic empty;

    tgf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .i_full      (full)
    );

    tgf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_cmd),
        .o_empty (empty)
    );

    tgf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_empty    (empty),
        .o_pop      (pop),
        .i_cmd      (pop_cmd),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ----- verif/tripod_gait_foot_trajectory_unit_checker.sv -----
// ----------------------------------------------------------------------------
// tripod_gait_foot_trajectory_unit_checker
// watches the command, foot target and register channels, predicts the six
// foot targets of every tick from its own gait state and compares them
// ----------------------------------------------------------------------------
module tripod_gait_foot_trajectory_unit_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [55:0] i_m_tdata,
    input  logic        i_m_tuser,
    input  logic        i_m_tlast,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tgf_pkg::*;

    typedef struct packed {
        logic [2:0]         leg;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               swing;
        logic               last;
    } t_foot;

    t_foot       foot_q[$];
    logic [15:0] cos_tab [0:TRIG_TABLE_DEPTH];
    t_cfg        regs;
    t_gait       gait;
    logic [31:0] origin;

    function automatic void make_cos_tab();
        longint unsigned x, x2, term, div, v;
        longint          sum;
        for (int i = 0; i <= TRIG_TABLE_DEPTH; i++) begin
            x    = 64'd1686629713 * i / TRIG_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = term;
            for (int k = 1; k <= 6; k++) begin
                div  = (2 * k - 1) * (2 * k);
                term = ((term * x2) >> 30) / div;
                if (k % 2) sum -= term; else sum += term;
            end
            if (sum < 0) sum = 0;
            v = (sum + 16384) >> 15;
            if (v > 32768) v = 32768;
            cos_tab[i] = v[15:0];
        end
    endfunction

    function automatic longint qcos(longint unsigned u);
        longint unsigned p, idx, fr;
        p   = u * TRIG_TABLE_DEPTH;
        idx = p >> 16;
        fr  = p & 16'hffff;
        if (idx >= TRIG_TABLE_DEPTH) return cos_tab[TRIG_TABLE_DEPTH];
        return (cos_tab[idx] * (65536 - fr) + cos_tab[idx + 1] * fr + 32768) >> 16;
    endfunction

    function automatic longint rshift(longint v, int k);
        longint a;
        a = v + (longint'(1) << (k - 1));
        return a >>> k;
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return -16'sh8000;
        return v[15:0];
    endfunction

    function automatic longint ratio(logic [15:0] r);
        longint v;
        v = signed'(r);
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        return v;
    endfunction

    task automatic predict_feet(logic [63:0] d);
        logic [31:0]     tick, elapsed;
        longint unsigned rem, s;
        longint          ex, ey, dx, dy, dz, c, w;
        logic [15:0]     phase, lp;
        logic            neutral;
        t_foot           f;
        tick    = d[31:0];
        phase   = 0;
        neutral = 0;
        if (origin == 0) origin = tick;
        if (gait == GAIT_IDLE) begin
            neutral = 1;
        end else begin
            elapsed = tick - origin;
            rem     = elapsed % regs.cycle_period;
            phase   = (rem << 16) / regs.cycle_period;
            if (gait == GAIT_STOP && elapsed >= regs.cycle_period) begin
                gait    = GAIT_IDLE;
                neutral = 1;
            end
        end
        ex = longint'(regs.stride_len) * ratio(d[47:32]);
        ey = longint'(regs.side_stride) * 16384
           + longint'(regs.stride_len) * ratio(d[63:48]);
        for (int i = 0; i < LEG_COUNT; i++) begin
            dx = 0; dy = 0; dz = 0;
            f.swing = 0;
            if (!neutral) begin
                lp = phase + (LEG_GROUP[i] ? 16'h8000 : 16'h0);
                if (lp < 16'h8000) begin
                    s = 2 * lp;
                    c = (s < 32768) ? qcos(2 * s) : -qcos(2 * (65536 - s));
                    f.swing = 1;
                    dx = rshift(-ex * c, 30);
                    dy = rshift(-ey * c, 30);
                    dz = rshift(longint'(regs.lift_height)
                         * ((s < 32768) ? qcos(65536 - 2 * s) : qcos(2 * s - 65536)), 15);
                end else begin
                    w  = 32768 - 2 * (longint'(lp) - 32768);
                    dx = rshift(ex * w, 30);
                    dy = rshift(ey * w, 30);
                end
            end
            f.leg  = 3'(i);
            f.x    = clip16(regs.neutral_reach + dx);
            f.y    = clip16(dy);
            f.z    = clip16(regs.neutral_height + dz);
            f.last = (i == LEG_COUNT - 1);
            foot_q.push_back(f);
        end
    endtask

    initial make_cos_tab();

    always @(posedge i_clk) begin
        t_foot got, want;
        if (!i_rst_n) begin
            regs   = '{960, 480, 1000, 0, 1600, -1280};
            gait   = GAIT_IDLE;
            origin = 0;
            foot_q.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STRIDE_LENGTH:  regs.stride_len = i_cfg_data[14:0];
                    CFG_STEP_HEIGHT:    regs.lift_height = i_cfg_data[14:0];
                    CFG_CYCLE_PERIOD:   if (i_cfg_data >= MIN_PERIOD)
                                            regs.cycle_period = i_cfg_data;
                    CFG_STRIDE_WIDTH:   regs.side_stride = i_cfg_data;
                    CFG_NEUTRAL_REACH:  regs.neutral_reach = i_cfg_data;
                    CFG_NEUTRAL_HEIGHT: regs.neutral_height = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                case (t_in_mode'(i_s_tuser))
                    CMD_START:  gait = GAIT_WALK;
                    CMD_STOP:   if (gait == GAIT_WALK) gait = GAIT_STOP;
                    CMD_FREEZE: gait = GAIT_IDLE;
                    default:    predict_feet(i_s_tdata);
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata[2:0], i_m_tdata[18:3], i_m_tdata[34:19],
                       i_m_tdata[50:35], i_m_tuser, i_m_tlast};
                if (foot_q.size() == 0) begin
                    $display("%0t: unexpected word leg %0d", $realtime, got.leg);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = foot_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected leg %0d x %0d y %0d z %0d sw %b last %b,",
                                 $realtime, want.leg, want.x, want.y, want.z,
                                 want.swing, want.last);
                        $display("   actual leg %0d x %0d y %0d z %0d sw %b last %b",
                                 got.leg, got.x, got.y, got.z, got.swing, got.last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= foot_q.size();
        end
    end
endmodule

// ----- verif/tripod_gait_foot_trajectory_unit_test.sv -----
// ----------------------------------------------------------------------------
// tripod_gait_foot_trajectory_unit_test
// drives gait commands, ticks and register writes with random gaps and
// back-pressure; the checker predicts and compares every foot target
// ----------------------------------------------------------------------------
module tripod_gait_foot_trajectory_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tgf_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_tvalid = 0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = 0;
    logic [1:0]  i_s_tuser = 0;
    logic        o_m_tvalid;
    logic        i_m_tready = 0;
    logic [55:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = 0;
    logic [15:0] i_cfg_data = 0;
    int          fail_count;
    int          pending;
    bit          calm = 0;
    logic [31:0] now_ms = 1;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    tripod_gait_foot_trajectory_unit i_dut (.*);

    tripod_gait_foot_trajectory_unit_checker i_chk (
        .i_clk, .i_rst_n, .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata,
        .i_s_tuser, .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .i_m_tuser(o_m_tuser), .i_m_tlast(o_m_tlast), .i_cfg_valid,
        .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        int n;
        if (calm || $urandom_range(0, 3) != 0) begin
            i_m_tready <= 1;
        end else begin
            n = $urandom_range(1, 18);
            i_m_tready <= 0;
            repeat (n - 1) @(posedge i_clk);
            i_m_tready <= 1;
        end
    end

    task automatic send(t_in_mode m, logic [31:0] t, logic [15:0] f, logic [15:0] s);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser  <= m;
        i_s_tdata  <= {s, f, t};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic tick(logic [15:0] f, logic [15:0] s);
        send(CMD_TICK, now_ms, f, s);
        now_ms += $urandom_range(1, 150);
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    function automatic logic [15:0] rand_ratio();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            default: return 16'($urandom_range(0, 32768)) - 16'd16384;
        endcase
    endfunction

    initial begin
        t_in_mode m;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: idle ticks, zero time, start, stop to idle, freeze
        send(CMD_TICK, 0, 16'h4000, 16'hc000);
        tick(16'h7fff, 16'h8000);
        send(CMD_START, 0, 0, 0);
        send(CMD_START, 0, 0, 0);
        tick(16'h4000, 16'h0000);
        tick(16'hc000, 16'h4000);
        tick(16'h4001, 16'hbfff);
        send(CMD_STOP, 0, 0, 0);
        send(CMD_STOP, 0, 0, 0);
        tick(16'h4000, 16'h4000);
        now_ms += 1200;
        tick(16'h4000, 16'h4000);
        send(CMD_START, 0, 0, 0);
        tick(16'h2000, 16'h1000);
        send(CMD_FREEZE, 0, 0, 0);
        tick(16'h2000, 16'h1000);
        send(CMD_START, 0, 0, 0);
        send(CMD_TICK, 32'hffff_fff0, 16'h4000, 16'h0);
        send(CMD_TICK, 32'h0000_0100, 16'h4000, 16'h0);
        drain();
        for (int phase_n = 0; phase_n < 6; phase_n++) begin
            if (phase_n == 5) calm = 1;
            case (phase_n)
                0: begin
                    write_reg(CFG_STRIDE_LENGTH, 16'h7fff);
                    write_reg(CFG_STEP_HEIGHT, 16'h7fff);
                    write_reg(CFG_CYCLE_PERIOD, 16'd200);
                    write_reg(CFG_STRIDE_WIDTH, 16'h7fff);
                    write_reg(CFG_NEUTRAL_REACH, 16'h7fff);
                    write_reg(CFG_NEUTRAL_HEIGHT, 16'h7fff);
                end
                1: begin
                    write_reg(CFG_STRIDE_LENGTH, 0);
                    write_reg(CFG_STEP_HEIGHT, 0);
                    write_reg(CFG_CYCLE_PERIOD, 16'd199);
                    write_reg(CFG_CYCLE_PERIOD, 16'hffff);
                    write_reg(CFG_STRIDE_WIDTH, 16'h8000);
                    write_reg(CFG_NEUTRAL_REACH, 16'h8000);
                    write_reg(CFG_NEUTRAL_HEIGHT, 16'h8000);
                    write_reg(3'd7, 16'h1234);
                end
                default: begin
                    for (int r = 0; r < 6; r++)
                        write_reg(3'(r), (r == CFG_CYCLE_PERIOD) ? 16'($urandom_range(150, 1500))
                                                                 : 16'($urandom));
                end
            endcase
            i_cfg_valid <= 0;
            for (int n = 0; n < 25; n++) begin
                case ($urandom_range(0, 19))
                    0: m = CMD_START;
                    1: m = CMD_STOP;
                    2: m = CMD_FREEZE;
                    default: m = CMD_TICK;
                endcase
                if (m == CMD_TICK) begin
                    if ($urandom_range(0, 29) == 0) now_ms = $urandom;
                    if ($urandom_range(0, 29) == 0) now_ms = 0;
                    tick(rand_ratio(), rand_ratio());
                end else begin
                    send(m, $urandom, 16'($urandom), 16'($urandom));
                end
            end
            drain();
        end
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("FAIL");
        $finish;
    end
endmodule

// ----- tripod_gait_foot_trajectory_unit.f -----
rtl/core/tgf_pkg.sv
rtl/core/tgf_queue.sv
rtl/core/tgf_front.sv
rtl/core/tgf_back.sv
rtl/core/tripod_gait_foot_trajectory_unit.sv
verif/tripod_gait_foot_trajectory_unit_checker.sv
verif/tripod_gait_foot_trajectory_unit_test.sv
